FILE: sv/md2_pkg.sv
// ----------------------------------------------------------------------------
// md2_pkg
// shared types, constants and the substitution table of the md2 hash engine
// ----------------------------------------------------------------------------
package md2_pkg;

  localparam int ROUNDS      = 18;
  localparam int STATE_BYTES = 48;
  localparam int BLOCK_BYTES = 16;
  localparam int LAST_BYTE   = 15;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] blk_idx_t;
  typedef logic [5:0] mix_addr_t;
  typedef logic [4:0] aux_addr_t;
  typedef logic [4:0] rnd_t;

  // mix memory access request
  typedef struct packed {
    logic      rd_en;
    mix_addr_t rd_addr;
    logic      wr_en;
    mix_addr_t wr_addr;
    byte_t     wr_data;
    logic      clear;
  } mix_req_t;

  // block buffer (lower half) and checksum (upper half) access request
  typedef struct packed {
    logic      rd_en;
    blk_idx_t  rd_idx;
    logic      wr_en;
    aux_addr_t wr_addr;
    byte_t     wr_data;
    logic      clear;
  } aux_req_t;

  localparam byte_t SUBST [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

FILE: sv/md2_chan_if.sv
// ----------------------------------------------------------------------------
// md2 channel interfaces
// valid/ready channels for message bytes in and digest bytes out
// ----------------------------------------------------------------------------
interface md2_byte_if;
  import md2_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  byte_valid;
  logic  end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

interface md2_digest_if;
  import md2_pkg::*;

  logic  valid;
  logic  ready;
  byte_t digest_byte;
  logic  digest_last;

  modport source (output valid, output digest_byte, output digest_last, input ready);
  modport sink   (input valid, input digest_byte, input digest_last, output ready);
endinterface

FILE: sv/md2_mix_mem.sv
// ----------------------------------------------------------------------------
// md2_mix_mem
// 48-byte mixing state memory, registered read, per-entry valid flags
// ----------------------------------------------------------------------------
module md2_mix_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  md2_pkg::mix_req_t req,
  output md2_pkg::byte_t    rd_data
);
  import md2_pkg::*;

  byte_t                  mem [STATE_BYTES];
  logic [STATE_BYTES-1:0] vld_r;
  byte_t                  rd_raw_r;
  logic                   rd_ok_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr];
    end
  end

  // entries never written since reset or the last digest read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (req.clear) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_raw_r : '0;

endmodule

FILE: sv/md2_aux_mem.sv
// ----------------------------------------------------------------------------
// md2_aux_mem
// block buffer and running checksum in one 32-byte memory, two read ports
// ----------------------------------------------------------------------------
module md2_aux_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  md2_pkg::aux_req_t req,
  output md2_pkg::byte_t    buf_data,
  output md2_pkg::byte_t    csum_data
);
  import md2_pkg::*;

  byte_t                  mem [2*BLOCK_BYTES];
  logic [BLOCK_BYTES-1:0] csum_vld_r;
  byte_t                  buf_r;
  byte_t                  csum_raw_r;
  logic                   csum_ok_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      buf_r      <= mem[{1'b0, req.rd_idx}];
      csum_raw_r <= mem[{1'b1, req.rd_idx}];
    end
  end

  // only the checksum half has a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_vld_r <= '0;
      csum_ok_r  <= 1'b0;
    end else begin
      if (req.clear) begin
        csum_vld_r <= '0;
      end else if (req.wr_en && req.wr_addr[4]) begin
        csum_vld_r[req.wr_addr[3:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        csum_ok_r <= csum_vld_r[req.rd_idx];
      end
    end
  end

  assign buf_data  = buf_r;
  assign csum_data = csum_ok_r ? csum_raw_r : '0;

endmodule

FILE: sv/md2_seq.sv
// ----------------------------------------------------------------------------
// md2_seq
// sequencer: byte intake, block load, 18 mixing rounds and digest readout
// ----------------------------------------------------------------------------
module md2_seq (
  input  logic              clk,
  input  logic              rst_n,
  md2_byte_if.sink          in_ch,
  md2_digest_if.source      out_ch,
  output md2_pkg::mix_req_t mix_req,
  input  md2_pkg::byte_t    mix_rd_data,
  output md2_pkg::aux_req_t aux_req,
  input  md2_pkg::byte_t    buf_rd_data,
  input  md2_pkg::byte_t    csum_rd_data
);
  import md2_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_LD_RD = 4'd2;
  localparam logic [3:0] S_LD_W1 = 4'd3;
  localparam logic [3:0] S_LD_W2 = 4'd4;
  localparam logic [3:0] S_PRIME = 4'd5;
  localparam logic [3:0] S_RND   = 4'd6;
  localparam logic [3:0] S_OUT_RD = 4'd7;
  localparam logic [3:0] S_OUT_LD = 4'd8;

  localparam logic [1:0] KIND_MSG  = 2'd0;
  localparam logic [1:0] KIND_PAD  = 2'd1;
  localparam logic [1:0] KIND_CSUM = 2'd2;

  localparam blk_idx_t  IDX_LAST = blk_idx_t'(LAST_BYTE);
  localparam mix_addr_t J_LAST   = mix_addr_t'(STATE_BYTES - 1);
  localparam rnd_t      RND_LAST = rnd_t'(ROUNDS - 1);

  logic [3:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  blk_idx_t   fill_r, fill_nxt;
  logic       eom_r, eom_nxt;
  blk_idx_t   idx_r, idx_nxt;
  mix_addr_t  j_r, j_nxt;
  rnd_t       rnd_r, rnd_nxt;
  byte_t      t_r, t_nxt;
  byte_t      last_r, last_nxt;
  byte_t      blk_r, blk_nxt;
  byte_t      lo_r, lo_nxt;
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       in_xfer;
  byte_t      blk;
  byte_t      pad_len;
  byte_t      new_csum;
  byte_t      new_mix;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_xfer            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_byte = out_byte_r;
  assign out_ch.digest_last = out_last_r;

  assign pad_len  = 8'(BLOCK_BYTES) - {4'b0000, fill_r};
  assign new_csum = csum_rd_data ^ SUBST[blk ^ last_r];
  assign new_mix  = mix_rd_data ^ SUBST[t_r];

  // block byte: checksum for the final block, pad bytes past the fill point
  always_comb begin
    if (kind_r == KIND_CSUM) begin
      blk = csum_rd_data;
    end else if (kind_r == KIND_PAD && idx_r >= fill_r) begin
      blk = pad_len;
    end else begin
      blk = buf_rd_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    fill_nxt      = fill_r;
    eom_nxt       = eom_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    rnd_nxt       = rnd_r;
    t_nxt         = t_r;
    last_nxt      = last_r;
    blk_nxt       = blk_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    mix_req       = '0;
    aux_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.byte_valid) begin
            aux_req.wr_en   = 1'b1;
            aux_req.wr_addr = {1'b0, fill_r};
            aux_req.wr_data = in_ch.data_byte;
            fill_nxt        = fill_r + 4'd1;
          end
          if (in_ch.byte_valid && fill_r == IDX_LAST) begin
            kind_nxt  = KIND_MSG;
            eom_nxt   = in_ch.end_of_message;
            state_nxt = S_PRE;
          end else if (in_ch.end_of_message) begin
            kind_nxt  = KIND_PAD;
            state_nxt = S_PRE;
          end
        end
      end
      S_PRE: begin
        // fetch the last checksum byte to seed the chain
        aux_req.rd_en  = 1'b1;
        aux_req.rd_idx = IDX_LAST;
        idx_nxt        = '0;
        state_nxt      = S_LD_RD;
      end
      S_LD_RD: begin
        if (idx_r == '0) begin
          last_nxt = csum_rd_data;
        end
        mix_req.rd_en   = 1'b1;
        mix_req.rd_addr = {2'b00, idx_r};
        aux_req.rd_en   = 1'b1;
        aux_req.rd_idx  = idx_r;
        state_nxt       = S_LD_W1;
      end
      S_LD_W1: begin
        mix_req.wr_en   = 1'b1;
        mix_req.wr_addr = {2'b01, idx_r};
        mix_req.wr_data = blk;
        blk_nxt         = blk;
        lo_nxt          = mix_rd_data;
        if (kind_r != KIND_CSUM) begin
          aux_req.wr_en   = 1'b1;
          aux_req.wr_addr = {1'b1, idx_r};
          aux_req.wr_data = new_csum;
          last_nxt        = new_csum;
        end
        state_nxt = S_LD_W2;
      end
      S_LD_W2: begin
        mix_req.wr_en   = 1'b1;
        mix_req.wr_addr = {2'b10, idx_r};
        mix_req.wr_data = blk_r ^ lo_r;
        if (idx_r == IDX_LAST) begin
          t_nxt     = '0;
          rnd_nxt   = '0;
          j_nxt     = '0;
          state_nxt = S_PRIME;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_LD_RD;
        end
      end
      S_PRIME: begin
        mix_req.rd_en   = 1'b1;
        mix_req.rd_addr = '0;
        state_nxt       = S_RND;
      end
      S_RND: begin
        // one dependent lookup per cycle, next entry prefetched
        mix_req.wr_en   = 1'b1;
        mix_req.wr_addr = j_r;
        mix_req.wr_data = new_mix;
        if (j_r == J_LAST) begin
          t_nxt = new_mix + {3'b000, rnd_r};
          j_nxt = '0;
          if (rnd_r == RND_LAST) begin
            idx_nxt = '0;
            unique case (kind_r)
              KIND_MSG: begin
                if (eom_r) begin
                  kind_nxt  = KIND_PAD;
                  eom_nxt   = 1'b0;
                  state_nxt = S_PRE;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
              KIND_PAD: begin
                kind_nxt  = KIND_CSUM;
                state_nxt = S_PRE;
              end
              default: begin
                state_nxt = S_OUT_RD;
              end
            endcase
          end else begin
            rnd_nxt         = rnd_r + 5'd1;
            mix_req.rd_en   = 1'b1;
            mix_req.rd_addr = '0;
          end
        end else begin
          t_nxt           = new_mix;
          j_nxt           = j_r + 6'd1;
          mix_req.rd_en   = 1'b1;
          mix_req.rd_addr = j_r + 6'd1;
        end
      end
      S_OUT_RD: begin
        if (!out_valid_r) begin
          mix_req.rd_en   = 1'b1;
          mix_req.rd_addr = {2'b00, idx_r};
          state_nxt       = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = mix_rd_data;
        out_last_nxt  = (idx_r == IDX_LAST);
        if (idx_r == IDX_LAST) begin
          // digest captured: back to the initial state
          mix_req.clear = 1'b1;
          aux_req.clear = 1'b1;
          fill_nxt      = '0;
          eom_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_MSG;
      fill_r      <= '0;
      eom_r       <= 1'b0;
      idx_r       <= '0;
      j_r         <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      fill_r      <= fill_nxt;
      eom_r       <= eom_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    last_r     <= last_nxt;
    blk_r      <= blk_nxt;
    lo_r       <= lo_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: sv/md2_hash_engine_top.sv
// intake: an item is accepted whenever the sequencer is idle
// a byte that completes a block holds the input while the block is absorbed: a checksum
//   seed read, a read and two state writes per block byte, a prime read and 18 x 48 lookups
// end of message runs up to three such blocks (data, pad, checksum), then
//   reads out 16 digest bytes, each read waiting out any output backpressure
// reset: synchronous active-low; state and checksum valid flags clear at once
// ----------------------------------------------------------------------------
// md2_hash_engine_top
// md2 digest engine over a byte stream, state held in two small memories
// ----------------------------------------------------------------------------
module md2_hash_engine_top (
  input  logic         clk,
  input  logic         rst_n,
  md2_byte_if.sink     in_ch,
  md2_digest_if.source out_ch
);
  import md2_pkg::*;

  // mixing state memory requests and read data
  mix_req_t mix_req;
  byte_t    mix_rd_data;

  // block buffer and checksum memory requests and read data
  aux_req_t aux_req;
  byte_t    buf_rd_data;
  byte_t    csum_rd_data;

  // sequencer owns every transfer on both channels
  md2_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mix_req      (mix_req),
    .mix_rd_data  (mix_rd_data),
    .aux_req      (aux_req),
    .buf_rd_data  (buf_rd_data),
    .csum_rd_data (csum_rd_data)
  );

  // 48-byte state: read-modify-write every cycle during the rounds
  md2_mix_mem u_mix_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mix_req),
    .rd_data (mix_rd_data)
  );

  // message bytes in the lower half, running checksum in the upper half
  md2_aux_mem u_aux_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (aux_req),
    .buf_data  (buf_rd_data),
    .csum_data (csum_rd_data)
  );

endmodule

FILE: test/md2_digest_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md2 digest scoreboard
// bit-true md2 predictor and an ordered store of expected digest bytes
// ----------------------------------------------------------------------------
package md2_digest_sb_pkg;
  import md2_pkg::byte_t;

  typedef logic [15:0][7:0] block_t;

  typedef struct packed {
    byte_t digest_byte;
    logic  digest_last;
  } digest_exp_t;

  // pi-derived permutation, kept apart from the design's copy
  localparam byte_t PI_SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  class md2_digest_scoreboard;
    byte_t       hash_state [48];
    byte_t       chk_sum [16];
    block_t      byte_buf;
    int unsigned buf_fill;

    digest_exp_t pending_digest [$];

    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_messages;
    int unsigned n_msg_bytes;
    int unsigned n_blocks;

    function new();
      n_errors    = 0;
      n_checked   = 0;
      n_messages  = 0;
      n_msg_bytes = 0;
      n_blocks    = 0;
      restart_message();
    endfunction

    function void restart_message();
      foreach (hash_state[i]) hash_state[i] = '0;
      foreach (chk_sum[i]) chk_sum[i] = '0;
      byte_buf = '0;
      buf_fill = 0;
    endfunction

    // state load and checksum update, then 18 rounds over the 48-byte state
    function void absorb_block(block_t blk);
      byte_t carry;
      byte_t t;
      carry = chk_sum[15];
      for (int i = 0; i < 16; i++) begin
        hash_state[16 + i] = blk[i];
        hash_state[32 + i] = blk[i] ^ hash_state[i];
        chk_sum[i] = chk_sum[i] ^ PI_SBOX[blk[i] ^ carry];
        carry = chk_sum[i];
      end
      t = '0;
      for (int r = 0; r < 18; r++) begin
        for (int j = 0; j < 48; j++) begin
          hash_state[j] = hash_state[j] ^ PI_SBOX[t];
          t = hash_state[j];
        end
        t = byte_t'(t + r);
      end
      n_blocks++;
    endfunction

    function void take_byte_item(byte_t data, logic has_byte, logic closes);
      block_t      sum_blk;
      byte_t       pad;
      digest_exp_t e;
      if (has_byte) begin
        byte_buf[buf_fill] = data;
        buf_fill = (buf_fill + 1) % 16;
        n_msg_bytes++;
        if (buf_fill == 0) absorb_block(byte_buf);
      end
      if (!closes) return;
      pad = byte_t'(16 - buf_fill);
      for (int i = buf_fill; i < 16; i++) byte_buf[i] = pad;
      absorb_block(byte_buf);
      for (int i = 0; i < 16; i++) sum_blk[i] = chk_sum[i];
      absorb_block(sum_blk);
      for (int i = 0; i < 16; i++) begin
        e.digest_byte = hash_state[i];
        e.digest_last = (i == 15);
        pending_digest.push_back(e);
      end
      n_messages++;
      restart_message();
    endfunction

    function void check_digest_byte(byte_t got_byte, logic got_last);
      digest_exp_t e;
      if (pending_digest.size() == 0) begin
        $display("%0t: digest byte %02h (last %b) with nothing expected",
                 $time, got_byte, got_last);
        n_errors++;
        return;
      end
      e = pending_digest.pop_front();
      n_checked++;
      if (got_byte !== e.digest_byte) begin
        $display("%0t: digest_byte mismatch, expected %02h, actual %02h",
                 $time, e.digest_byte, got_byte);
        n_errors++;
      end
      if (got_last !== e.digest_last) begin
        $display("%0t: digest_last mismatch, expected %b, actual %b",
                 $time, e.digest_last, got_last);
        n_errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_digest.size();
    endfunction
  endclass

endpackage

FILE: test/tb_md2_hash_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md2_hash_engine_top
// feeds byte messages of many lengths and data patterns into the md2 engine
// with random gaps on both channels and checks every digest byte in order
// ----------------------------------------------------------------------------
module tb_md2_hash_engine_top;
  import md2_pkg::*;
  import md2_digest_sb_pkg::*;

  // data patterns for message contents
  typedef enum int {
    PAT_ZERO,
    PAT_ONES,
    PAT_COUNT,
    PAT_RANDOM
  } pattern_e;

  localparam int unsigned RANDOM_ITEMS = 310;

  logic clk;
  logic rst_n;

  md2_byte_if   in_if();
  md2_digest_if out_if();

  md2_hash_engine_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  md2_digest_scoreboard sb;

  bit          in_gaps_on;   // cleared for back-to-back stretches
  int unsigned n_items;      // transfers that carry a byte or an end

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // one input transfer: optional gap, then hold valid until ready is seen
  task automatic send_item(byte_t data, logic has_byte, logic closes);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= data;
    in_if.byte_valid     <= has_byte;
    in_if.end_of_message <= closes;
    // sampled at the rising edge, before the design updates
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.take_byte_item(data, has_byte, closes);
    if (has_byte || closes) n_items++;
  endtask

  // extremes and the corner cases of message framing
  task automatic run_directed();
    // neither byte nor end: must be ignored
    send_item(8'h5A, 1'b0, 1'b0);
    // end with no byte at all: digest of the empty message
    send_item(8'h00, 1'b0, 1'b1);
    // byte and end in one transfer
    send_item(8'h00, 1'b1, 1'b1);
    // byte, then a separate end without byte
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // exactly one block closed on its last byte: a full block of padding
    for (int i = 0; i < 16; i++) begin
      send_item(i[0] ? 8'hFF : 8'h00, 1'b1, i == 15);
    end
  endtask

  // one well-formed message with random length, contents and close style
  task automatic send_message();
    int unsigned len;
    int unsigned pick;
    pattern_e    pat;
    logic        end_on_byte;
    byte_t       d;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      len = $urandom_range(0, 20);
    end else if (pick < 17) begin
      // lengths around the block boundary: pad of 1, 16 or 15 bytes
      case ($urandom_range(0, 5))
        0:       len = 15;
        1:       len = 16;
        2:       len = 17;
        3:       len = 31;
        4:       len = 32;
        default: len = 33;
      endcase
    end else begin
      len = $urandom_range(21, 48);
    end
    pat = ($urandom_range(0, 2) == 0) ? pattern_e'($urandom_range(0, 2)) : PAT_RANDOM;
    end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    in_gaps_on  = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < len; i++) begin
      // now and then an empty transfer in the middle of the message
      if ($urandom_range(0, 9) == 0) send_item(byte_t'($urandom), 1'b0, 1'b0);
      case (pat)
        PAT_ZERO:  d = 8'h00;
        PAT_ONES:  d = 8'hFF;
        PAT_COUNT: d = byte_t'(i);
        default:   d = byte_t'($urandom);
      endcase
      send_item(d, 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) send_item(byte_t'($urandom), 1'b0, 1'b1);
  endtask

  // digest side: random stall before each byte, stall-free runs now and then
  initial begin : digest_sink
    int unsigned stall;
    bit          stalls_on;
    stalls_on = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      stall = stalls_on ? $urandom_range(0, 16) : 0;
      @(negedge clk);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      sb.check_digest_byte(out_if.digest_byte, out_if.digest_last);
      // pick a new stall style per digest
      if (out_if.digest_last === 1'b1) stalls_on = ($urandom_range(0, 3) != 0);
    end
  end

  // main sequence
  initial begin : stimulus
    sb                   = new();
    n_items              = 0;
    in_gaps_on           = 1'b1;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.byte_valid     = 1'b0;
    in_if.end_of_message = 1'b0;
    out_if.ready         = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // random messages until enough transfers have gone in
    n_items = 0;
    while (n_items < RANDOM_ITEMS) send_message();

    @(negedge clk);
    in_if.valid <= 1'b0;

    // drain, then watch a while for stray digest bytes
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d messages, %0d message bytes, %0d compressed blocks",
             sb.n_messages, sb.n_msg_bytes, sb.n_blocks);
    $display("checked %0d digest bytes, %0d errors", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin : watchdog
    #50_000_000;
    $display("%0t: timeout, %0d digest bytes still expected", $time, sb.outstanding());
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
sv/md2_pkg.sv
sv/md2_chan_if.sv
sv/md2_mix_mem.sv
sv/md2_aux_mem.sv
sv/md2_seq.sv
sv/md2_hash_engine_top.sv
test/md2_digest_scoreboard.sv
test/tb_md2_hash_engine_top.sv
